FILE: src/jse_pkg.sv
// Shared types, character constants and helpers for the JSON string escaper.
`timescale 1ns / 1ps
package jse_pkg;

    // Input item: one raw string byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    // Result item: one byte of escaped text
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    // Escape class of a byte
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PLAIN   = 2'd0;
    localparam kind_t KIND_SHORT   = 2'd1;
    localparam kind_t KIND_UNICODE = 2'd2;

    // Classified item held between front and back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] esc_char;
        logic [7:0] raw;
        logic       string_end;
    } cls_item_t;

    // Byte index within one item's escaped text
    typedef logic [2:0] step_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CTRL_TOP  = 8'h20;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_U     = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOW_A     = 8'h61;

    // Index of the final byte for each class
    function automatic step_t last_step(input kind_t kind);
        step_t r;
        case (kind)
            KIND_PLAIN:   r = 3'd0;
            KIND_SHORT:   r = 3'd1;
            KIND_UNICODE: r = 3'd5;
            default:      r = 3'd0;
        endcase
        return r;
    endfunction

    // Lower-case hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = CH_ZERO + {4'd0, n};
        else
            r = CH_LOW_A + {4'd0, n} - 8'd10;
        return r;
    endfunction

endpackage

FILE: src/json_string_escaper_unit.sv
// An item pushed is first written into the queue, then its first byte into the output register.
// Throughput: one result byte per cycle while items wait and the consumer pops; a raw
// byte becomes 1, 2 or 6 result bytes in the output serializer (plain, short escape,
// \u00XX form); the front queue of QUEUE_DEPTH items keeps accepting until full.
// Reset: rst_n clears the queue and the output valid flag; empty is high afterward.
`timescale 1ns / 1ps
module json_string_escaper_unit
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    cls_item_t front_item;
    cls_item_t head;
    logic      head_valid;
    logic      head_pop;
    logic      wr_en;

    assign wr_en = push && !full;

    jse_front u_front (
        .in_item  (in_item),
        .cls_item (front_item)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (front_item),
        .full     (full),
        .rd_en    (head_pop),
        .rd_valid (head_valid),
        .rd_data  (head)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

endmodule

FILE: src/jse_front.sv
// Front end: classify a raw byte into its escape class.
`timescale 1ns / 1ps
module jse_front
    import jse_pkg::*;
(
    input  in_item_t  in_item,
    output cls_item_t cls_item
);

    // Pick the class and the short-escape letter
    always_comb
    begin
        cls_item.raw        = in_item.in_byte;
        cls_item.string_end = in_item.string_end;
        cls_item.esc_char   = in_item.in_byte;
        cls_item.kind       = KIND_PLAIN;
        case (in_item.in_byte)
            CH_QUOTE, CH_BACKSLASH:
            begin
                cls_item.kind = KIND_SHORT;
            end
            CH_BS:
            begin
                cls_item.kind     = KIND_SHORT;
                cls_item.esc_char = CH_LOW_B;
            end
            CH_FF:
            begin
                cls_item.kind     = KIND_SHORT;
                cls_item.esc_char = CH_LOW_F;
            end
            CH_LF:
            begin
                cls_item.kind     = KIND_SHORT;
                cls_item.esc_char = CH_LOW_N;
            end
            CH_CR:
            begin
                cls_item.kind     = KIND_SHORT;
                cls_item.esc_char = CH_LOW_R;
            end
            CH_TAB:
            begin
                cls_item.kind     = KIND_SHORT;
                cls_item.esc_char = CH_LOW_T;
            end
            default:
            begin
                if (in_item.in_byte < CH_CTRL_TOP)
                    cls_item.kind = KIND_UNICODE;
            end
        endcase
    end

endmodule

FILE: src/jse_queue.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cls_item_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output logic      rd_valid,
    output cls_item_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    cls_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_MAX);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: src/jse_back.sv
// Back end: serialize a classified item into escaped bytes.
`timescale 1ns / 1ps
module jse_back
    import jse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cls_item_t head,
    output logic      head_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;
    logic       load;
    logic       at_last;
    logic [7:0] cur_byte;

    assign load     = head_valid && (!out_valid_reg || pop);
    assign at_last  = (step_reg == last_step(head.kind));
    assign head_pop = load && at_last;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    // Select the byte for the current step
    always_comb
    begin
        cur_byte = head.raw;
        case (head.kind)
            KIND_SHORT:
            begin
                cur_byte = (step_reg == 3'd0) ? CH_BACKSLASH : head.esc_char;
            end
            KIND_UNICODE:
            begin
                case (step_reg)
                    3'd0:    cur_byte = CH_BACKSLASH;
                    3'd1:    cur_byte = CH_LOW_U;
                    3'd2:    cur_byte = CH_ZERO;
                    3'd3:    cur_byte = CH_ZERO;
                    3'd4:    cur_byte = hex_digit(head.raw[7:4]);
                    default: cur_byte = hex_digit(head.raw[3:0]);
                endcase
            end
            default:
            begin
                cur_byte = head.raw;
            end
        endcase
    end

    // Advance the step and hold or refill the output register
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = at_last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_byte    <= cur_byte;
            out_reg.run_last    <= at_last;
            out_reg.string_done <= at_last && head.string_end;
        end
    end

endmodule

FILE: src/jse_checker.sv
// Port-level checker for the escaper and its bind to the top level.
`timescale 1ns / 1ps
module jse_checker
    import jse_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    // Hold a waiting item until it is taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(out_item))
        else $error("result item changed while stalled");

    // End of string only on the final byte of an item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.string_done) |-> out_item.run_last)
        else $error("string_done without run_last");

    // A multi-byte run opens with a backslash
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_item.run_last) |=>
            (empty || out_item.run_last || out_item.out_byte == CH_BACKSLASH))
        else $error("escape run does not start with backslash");

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
